### rtl/straight_alpha_over_blend_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the straight alpha over blend core
// Shared property forms for the checker that watches the core's ports.
// ----------------------------------------------------------------------------
`ifndef STRAIGHT_ALPHA_OVER_BLEND_CORE_ASSERT_SVH
`define STRAIGHT_ALPHA_OVER_BLEND_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAOB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("saob assertion failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define SAOB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("saob assertion failed: next-cycle property");

`endif

### rtl/saob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saob_pkg
// Widths, constants and the divider step shared by the blend core and checker.
// ----------------------------------------------------------------------------
package saob_pkg;

  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int N_CH        = 3;
  localparam int D_W         = 16;
  localparam int NUM_W       = 24;
  localparam int TDATA_IN_W  = 2 * PIX_W;
  localparam int TDATA_OUT_W = PIX_W;

  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = CH_W / DIV_STAGES;
  // Two product stages ahead of the divider stages.
  localparam int PIPE_DEPTH     = 2 + DIV_STAGES;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  localparam int ALPHA_LSB = 24;

  typedef logic [CH_W-1:0]  ch_t;
  typedef logic [D_W-1:0]   den_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    num_t rem;
    logic q;
  } div_bit_t;

  // One restoring division step: try to subtract the denominator shifted up.
  function automatic div_bit_t div_bit(input num_t rem, input den_t d,
                                       input int unsigned shift);
    num_t     dd;
    div_bit_t r;
    dd = NUM_W'(d) << shift;
    if (rem >= dd) begin
      r.rem = rem - dd;
      r.q   = 1'b1;
    end else begin
      r.rem = rem;
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/straight_alpha_over_blend_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_alpha_over_blend_core
// Porter-Duff "over" of a straight-alpha BGRA8888 source pixel onto a target.
// ----------------------------------------------------------------------------
// The core takes one pixel pair per clock and returns one blended pixel per
// clock while the output side does not stall. The first two stages form the
// weights, denominator and numerators; the remaining four stages are a
// restoring divider that settles two quotient bits per stage for each colour
// channel, and its last stage is the output register. A stall on the output
// fills bubbles first and backs up to s_axis_tready only when every stage
// holds a pixel. Output alpha is floor(D/255) with D = 255*sA + (255-sA)*tA;
// each colour is the exact floored quotient of the weighted colour sum by D,
// and all bytes are zero when D is 0.
module straight_alpha_over_blend_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] source_pixel, [63:32] target_pixel
  input  logic [saob_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] blended_pixel
  output logic [saob_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tlast
);
  import saob_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;

  // Stage one: target weight and source alpha times colour.
  logic [D_W-1:0] st1_tw;
  logic [D_W-1:0] st1_ssc [N_CH];
  ch_t            st1_sa;
  ch_t            st1_tc  [N_CH];
  logic           st1_last;

  // Stage two: denominator and numerators.
  den_t st2_d;
  num_t st2_num [N_CH];
  logic st2_last;

  // Divider stages.
  num_t dv_rem   [DIV_STAGES][N_CH];
  ch_t  dv_q     [DIV_STAGES][N_CH];
  den_t dv_d     [DIV_STAGES];
  ch_t  dv_alpha [DIV_STAGES];
  logic dv_dz    [DIV_STAGES];
  logic dv_last  [DIV_STAGES];

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_axis_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage one
  ch_t sa;
  ch_t ta;
  assign sa = s_axis_tdata[ALPHA_LSB +: CH_W];
  assign ta = s_axis_tdata[PIX_W + ALPHA_LSB +: CH_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st1_tw   <= D_W'(CH_MAX - sa) * D_W'(ta);
      st1_sa   <= sa;
      st1_last <= s_axis_tlast;
      for (int c = 0; c < N_CH; c++) begin
        st1_ssc[c] <= D_W'(sa) * D_W'(s_axis_tdata[c*CH_W +: CH_W]);
        st1_tc[c]  <= s_axis_tdata[PIX_W + c*CH_W +: CH_W];
      end
    end
  end

  // Stage two: multiplying by 255 is a shift and a subtract.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      st2_d    <= ((D_W'(st1_sa) << CH_W) - D_W'(st1_sa)) + st1_tw;
      st2_last <= st1_last;
      for (int c = 0; c < N_CH; c++) begin
        st2_num[c] <= ((NUM_W'(st1_ssc[c]) << CH_W) - NUM_W'(st1_ssc[c]))
                      + NUM_W'(st1_tw) * NUM_W'(st1_tc[c]);
      end
    end
  end

  // floor(d/255) equals ((d+1)*257) >> 16 over the whole range of d.
  logic [NUM_W-1:0] alpha_prod;
  logic [NUM_W-1:0] d_inc;
  assign d_inc      = NUM_W'(st2_d) + NUM_W'(1);
  assign alpha_prod = d_inc + (d_inc << CH_W);

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    num_t     rem_in [N_CH];
    ch_t      q_in   [N_CH];
    den_t     d_in;
    div_bit_t hi     [N_CH];
    div_bit_t lo     [N_CH];

    if (j == 0) begin : g_first
      always_comb begin
        d_in = st2_d;
        for (int c = 0; c < N_CH; c++) begin
          rem_in[c] = st2_num[c];
          q_in[c]   = '0;
        end
      end
      always_ff @(posedge clk) begin
        if (en[2]) begin
          dv_alpha[0] <= alpha_prod[2*CH_W +: CH_W];
          dv_dz[0]    <= (st2_d == '0);
          dv_last[0]  <= st2_last;
        end
      end
    end else begin : g_rest
      always_comb begin
        d_in = dv_d[j-1];
        for (int c = 0; c < N_CH; c++) begin
          rem_in[c] = dv_rem[j-1][c];
          q_in[c]   = dv_q[j-1][c];
        end
      end
      always_ff @(posedge clk) begin
        if (en[j+2]) begin
          dv_alpha[j] <= dv_alpha[j-1];
          dv_dz[j]    <= dv_dz[j-1];
          dv_last[j]  <= dv_last[j-1];
        end
      end
    end

    always_comb begin
      for (int c = 0; c < N_CH; c++) begin
        hi[c] = div_bit(rem_in[c], d_in, CH_W - 1 - j * BITS_PER_STAGE);
        lo[c] = div_bit(hi[c].rem, d_in, CH_W - 2 - j * BITS_PER_STAGE);
      end
    end

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        dv_d[j] <= d_in;
        for (int c = 0; c < N_CH; c++) begin
          dv_rem[j][c] <= lo[c].rem;
          dv_q[j][c]   <= {q_in[c][CH_W-BITS_PER_STAGE-1:0], hi[c].q, lo[c].q};
        end
      end
    end
  end

  // A zero denominator gives an all-ones quotient; force the colour bytes to zero.
  always_comb begin
    m_axis_tdata[ALPHA_LSB +: CH_W] = dv_alpha[DIV_STAGES-1];
    for (int c = 0; c < N_CH; c++) begin
      m_axis_tdata[c*CH_W +: CH_W] = dv_dz[DIV_STAGES-1] ? '0 : dv_q[DIV_STAGES-1][c];
    end
  end

  assign m_axis_tvalid = vld[PIPE_DEPTH-1];
  assign m_axis_tlast  = dv_last[DIV_STAGES-1];

endmodule

### rtl/saob_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saob_checker
// Port-level checks on the blend core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`include "straight_alpha_over_blend_core_assert.svh"

module saob_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [saob_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [saob_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);

  logic out_stall;
  logic out_beat;
  logic in_stall;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = m_axis_tvalid && m_axis_tready;
  assign in_stall  = s_axis_tvalid && !s_axis_tready;

  // A stalled output beat keeps its payload.
  `SAOB_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))

  // A waiting input beat is held by the source until it is taken.
  `SAOB_ASSERT_NEXT(a_in_hold, in_stall, s_axis_tvalid && $stable({s_axis_tlast, s_axis_tdata}))

  // Back-pressure on the input only ever comes from a stalled output.
  `SAOB_ASSERT_SAME(a_ready_source, !s_axis_tready, out_stall)

  // The pipeline starts empty after reset.
  `SAOB_ASSERT_SAME(a_empty_after_rst, $past(rst), !m_axis_tvalid)

  // With an idle input and a draining output, the input side is free again.
  `SAOB_ASSERT_NEXT(a_ready_after_drain, out_beat && !s_axis_tvalid, s_axis_tready)

endmodule

bind straight_alpha_over_blend_core saob_checker u_saob_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
